// File: hw/rtl/tcgr_pkg.sv
// -----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, constants and the colour palette for the text cell glyph
// renderer.
// -----------------------------------------------------------------------------
package tcgr_pkg;

   localparam int GLYPH_LINES  = 16;
   localparam int GRID_COLUMNS = 80;
   localparam int GRID_ROWS    = 25;

   localparam int FONT_DEPTH  = 4096;
   localparam int FONT_ADDR_W = $clog2(FONT_DEPTH);
   localparam int LINE_W      = $clog2(GLYPH_LINES);
   localparam int COORD_W     = 12;
   localparam int PITCH_W     = 15;
   localparam int OFFSET_W    = 26;
   localparam int PROD_W      = COORD_W + PITCH_W;
   localparam int PIXEL_W     = 24;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   // input actions
   localparam logic [1:0] ACT_PAINT  = 2'd0;
   localparam logic [1:0] ACT_CURSOR = 2'd1;
   localparam logic [1:0] ACT_FONT   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_READY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_PITCH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RGB_ORDER   = 3'd4;

   localparam logic [PITCH_W-1:0] LINE_PITCH_RESET = 15'd2560;
   localparam logic [PIXEL_W-1:0] COLOUR_WHITE     = 24'hffffff;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] grid_row;
      logic [6:0] grid_column;
      logic [7:0] char_code;
      logic [7:0] cell_attribute;
      logic       cursor_visible;
      logic [11:0] font_address;
      logic [7:0] font_byte;
   } tcgr_req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic [PIXEL_W-1:0]  pixel_0;
      logic [PIXEL_W-1:0]  pixel_1;
      logic [PIXEL_W-1:0]  pixel_2;
      logic [PIXEL_W-1:0]  pixel_3;
      logic [PIXEL_W-1:0]  pixel_4;
      logic [PIXEL_W-1:0]  pixel_5;
      logic [PIXEL_W-1:0]  pixel_6;
      logic [PIXEL_W-1:0]  pixel_7;
      logic                last_line;
   } tcgr_rsp_type;

   // 16 colour palette, red and blue bytes swapped when order is 0
   function automatic logic [PIXEL_W-1:0] pal_colour(input logic [3:0] idx,
                                                     input logic       order);
      logic [PIXEL_W-1:0] c;
      begin
         case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'h0000aa;
            4'd2:    c = 24'h00aa00;
            4'd3:    c = 24'h00aaaa;
            4'd4:    c = 24'haa0000;
            4'd5:    c = 24'haa00aa;
            4'd6:    c = 24'haa5500;
            4'd7:    c = 24'haaaaaa;
            4'd8:    c = 24'h555555;
            4'd9:    c = 24'h5555ff;
            4'd10:   c = 24'h55ff55;
            4'd11:   c = 24'h55ffff;
            4'd12:   c = 24'hff5555;
            4'd13:   c = 24'hff55ff;
            4'd14:   c = 24'hffff55;
            default: c = 24'hffffff;
         endcase
         pal_colour = order ? c : {c[7:0], c[15:8], c[23:16]};
      end
   endfunction

endpackage

// File: hw/rtl/text_cell_glyph_renderer.sv
// -----------------------------------------------------------------------------
// text_cell_glyph_renderer
// Text mode character generator: 8x16 font store loaded byte by byte, paints
// grid cells and cursors as lines of eight 24-bit pixels with frame offsets.
// -----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_ready  | tcgr_req_type (paint, cursor, font)
//  rsp_    | out       | rsp_valid/rsp_ready  | tcgr_rsp_type (one glyph line)
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
//  a paint item passes a setup state for the offset multiply, then one font
//  store read per line; a cursor item does the same for its last two lines;
//  a font write or a dropped item leaves the block idle. the single font store
//  read port sets the pace of one line per cycle while rsp_ is not stalled.
//  reset clears the registers to their defaults; font contents are undefined
//  until written. a stalled rsp_ freezes the read pipeline; the next item is
//  taken once the last line read of the current one is issued.
// -----------------------------------------------------------------------------
module text_cell_glyph_renderer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tcgr_pkg::tcgr_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tcgr_pkg::tcgr_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcgr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcgr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tcgr_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   localparam logic [LINE_W-1:0] LINE_LAST   = LINE_W'(GLYPH_LINES - 1);
   localparam logic [LINE_W-1:0] LINE_CURSOR = LINE_W'(GLYPH_LINES - 2);

   // configuration registers
   logic                frame_ready_ff;
   logic [10:0]         origin_x_ff;
   logic [10:0]         origin_y_ff;
   logic [PITCH_W-1:0]  line_pitch_ff;
   logic                rgb_order_ff;

   // sequencer
   logic [1:0]          state_ff, state_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic [COORD_W-1:0]  y_ff, y_in;
   logic [COORD_W-1:0]  x_ff, x_in;
   logic [7:0]          char_ff, char_in;
   logic [PIXEL_W-1:0]  fg_ff, fg_in;
   logic [PIXEL_W-1:0]  bg_ff, bg_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   // read stage
   logic                b_valid_ff;
   logic [OFFSET_W-1:0] b_offset_ff;
   logic                b_last_ff;
   logic [PIXEL_W-1:0]  b_fg_ff;
   logic [PIXEL_W-1:0]  b_bg_ff;

   // output stage
   logic                out_valid_ff;
   tcgr_rsp_type        out_data_ff, out_data_in;

   // font store
   logic [7:0]             font_store_ff [FONT_DEPTH];
   logic [7:0]             rd_data_ff;
   logic                   font_we;
   logic [FONT_ADDR_W-1:0] rd_addr;

   logic                req_accept;
   logic                draw_ok;
   logic                advance;
   logic                issue;
   logic [LINE_W-1:0]   start_line;
   logic [PROD_W-1:0]   product;
   logic [7:0]          glyph;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign advance = !out_valid_ff || rsp_ready;
   assign issue = (state_ff == ST_RUN) && advance;
   assign font_we = req_accept && (req_data.action == ACT_FONT);

   assign draw_ok = frame_ready_ff
                 && (32'(req_data.grid_row) < GRID_ROWS)
                 && (32'(req_data.grid_column) < GRID_COLUMNS)
                 && ((req_data.action == ACT_PAINT)
                     || ((req_data.action == ACT_CURSOR) && req_data.cursor_visible));

   assign start_line = (req_data.action == ACT_CURSOR) ? LINE_CURSOR : '0;
   assign product = PROD_W'(y_ff) * PROD_W'(line_pitch_ff);
   assign rd_addr = FONT_ADDR_W'(FONT_ADDR_W'(char_ff) * FONT_ADDR_W'(GLYPH_LINES)
                                 + FONT_ADDR_W'(line_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ready_ff <= 1'b0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         line_pitch_ff  <= LINE_PITCH_RESET;
         rgb_order_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FRAME_READY: frame_ready_ff <= csr_data[0];
            REG_ORIGIN_X:    origin_x_ff    <= csr_data[10:0];
            REG_ORIGIN_Y:    origin_y_ff    <= csr_data[10:0];
            REG_LINE_PITCH:  line_pitch_ff  <= csr_data[PITCH_W-1:0];
            REG_RGB_ORDER:   rgb_order_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      line_in   = line_ff;
      y_in      = y_ff;
      x_in      = x_ff;
      char_in   = char_ff;
      fg_in     = fg_ff;
      bg_in     = bg_ff;
      offset_in = offset_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && draw_ok) begin
               line_in = start_line;
               y_in    = COORD_W'(origin_y_ff)
                       + COORD_W'(req_data.grid_row) * COORD_W'(GLYPH_LINES)
                       + COORD_W'(start_line);
               x_in    = COORD_W'(origin_x_ff) + COORD_W'({req_data.grid_column, 3'b000});
               char_in = req_data.char_code;
               // a cursor paints white whatever the glyph bits are
               if (req_data.action == ACT_CURSOR) begin
                  fg_in = COLOUR_WHITE;
                  bg_in = COLOUR_WHITE;
               end else begin
                  fg_in = pal_colour(req_data.cell_attribute[3:0], rgb_order_ff);
                  bg_in = pal_colour(req_data.cell_attribute[7:4], rgb_order_ff);
               end
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            offset_in = OFFSET_W'(product) + OFFSET_W'({x_ff, 2'b00});
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (issue) begin
               offset_in = offset_ff + OFFSET_W'(line_pitch_ff);
               line_in   = line_ff + 1'b1;
               if (line_ff == LINE_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff   <= line_in;
      y_ff      <= y_in;
      x_ff      <= x_in;
      char_ff   <= char_in;
      fg_ff     <= fg_in;
      bg_ff     <= bg_in;
      offset_ff <= offset_in;
   end

   // font store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (font_we) begin
         font_store_ff[req_data.font_address] <= req_data.font_byte;
      end
      if (issue) begin
         rd_data_ff <= font_store_ff[rd_addr];
      end
   end

   // line info travels alongside the read so the next item may set up early
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_offset_ff <= offset_ff;
         b_last_ff   <= (line_ff == LINE_LAST);
         b_fg_ff     <= fg_ff;
         b_bg_ff     <= bg_ff;
      end
   end

   assign glyph = rd_data_ff;

   always_comb begin
      out_data_in.byte_offset = b_offset_ff;
      out_data_in.pixel_0     = glyph[7] ? b_fg_ff : b_bg_ff;
      out_data_in.pixel_1     = glyph[6] ? b_fg_ff : b_bg_ff;
      out_data_in.pixel_2     = glyph[5] ? b_fg_ff : b_bg_ff;
      out_data_in.pixel_3     = glyph[4] ? b_fg_ff : b_bg_ff;
      out_data_in.pixel_4     = glyph[3] ? b_fg_ff : b_bg_ff;
      out_data_in.pixel_5     = glyph[2] ? b_fg_ff : b_bg_ff;
      out_data_in.pixel_6     = glyph[1] ? b_fg_ff : b_bg_ff;
      out_data_in.pixel_7     = glyph[0] ? b_fg_ff : b_bg_ff;
      out_data_in.last_line   = b_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && b_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // font writes only happen between items
   assert property (@(posedge clock) disable iff (reset)
      font_we |-> (state_ff == ST_IDLE))
      else $error("font store written while an item is in flight");

   // a stalled transaction freezes the read stage behind it
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (b_valid_ff == $past(b_valid_ff)))
      else $error("read stage moved during a stall");

   // the line counter never runs past the last glyph line while reading
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (32'(line_ff) <= GLYPH_LINES - 1))
      else $error("glyph line counter out of range");

endmodule

// File: verif/tb.sv
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the text cell glyph renderer. Loads glyphs into the
// font store, paints cells and cursors under a range of register settings and
// checks every glyph line against a behavioural copy of the renderer kept in
// step with each accepted transaction.
// -----------------------------------------------------------------------------
module tb;
   import tcgr_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned IDLE_PCT      = 16;

   localparam logic [PIXEL_W-1:0] VGA_COLOURS [16] = '{
      24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
      24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
      24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
      24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tcgr_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tcgr_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow of the block's registers and font store
   logic cfg_frame_ready = 1'b0;
   logic [10:0] cfg_origin_x = '0;
   logic [10:0] cfg_origin_y = '0;
   logic [PITCH_W-1:0] cfg_line_pitch = LINE_PITCH_RESET;
   logic cfg_rgb_order = 1'b1;
   logic [7:0] glyph_shadow [FONT_DEPTH];

   // stimulus side bookkeeping of what has been loaded
   logic font_loaded [FONT_DEPTH];
   logic glyph_usable [256];
   logic [7:0] usable_glyphs [$];

   tcgr_req_type cell_pending_q [$];
   tcgr_rsp_type line_expect_q [$];

   logic req_accepted = 1'b0;
   int unsigned idle_pct = IDLE_PCT;
   int unsigned hold_asks = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   text_cell_glyph_renderer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [PIXEL_W-1:0] palette_rgb(input logic [3:0] idx);
      logic [PIXEL_W-1:0] c;
      c = VGA_COLOURS[idx];
      return cfg_rgb_order ? c : {c[7:0], c[15:8], c[23:16]};
   endfunction

   // expected glyph lines for one accepted transaction
   function automatic void predict_glyph_lines(input tcgr_req_type r);
      tcgr_rsp_type line_out;
      logic [PIXEL_W-1:0] fg;
      logic [PIXEL_W-1:0] bg;
      logic [7:0] bits;
      logic [11:0] addr;
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] offs;
      int first;
      if (r.action == ACT_FONT) begin
         glyph_shadow[r.font_address] = r.font_byte;
         return;
      end
      if (r.action != ACT_PAINT && r.action != ACT_CURSOR)
         return;
      if (!cfg_frame_ready || r.grid_row >= GRID_ROWS || r.grid_column >= GRID_COLUMNS)
         return;
      if (r.action == ACT_CURSOR && !r.cursor_visible)
         return;
      first = (r.action == ACT_CURSOR) ? GLYPH_LINES - 2 : 0;
      fg = (r.action == ACT_CURSOR) ? palette_rgb(4'hf) : palette_rgb(r.cell_attribute[3:0]);
      bg = palette_rgb(r.cell_attribute[7:4]);
      for (int ln = first; ln < GLYPH_LINES; ln++) begin
         addr = 12'(int'(r.char_code) * GLYPH_LINES + ln);
         bits = (r.action == ACT_CURSOR) ? 8'hff : glyph_shadow[addr];
         x = 64'(cfg_origin_x) + 64'(r.grid_column) * 64'd8;
         y = 64'(cfg_origin_y) + 64'(r.grid_row) * 64'(GLYPH_LINES) + 64'(ln);
         offs = y * 64'(cfg_line_pitch) + x * 64'd4;
         line_out.byte_offset = offs[OFFSET_W-1:0];
         line_out.pixel_0 = bits[7] ? fg : bg;
         line_out.pixel_1 = bits[6] ? fg : bg;
         line_out.pixel_2 = bits[5] ? fg : bg;
         line_out.pixel_3 = bits[4] ? fg : bg;
         line_out.pixel_4 = bits[3] ? fg : bg;
         line_out.pixel_5 = bits[2] ? fg : bg;
         line_out.pixel_6 = bits[1] ? fg : bg;
         line_out.pixel_7 = bits[0] ? fg : bg;
         line_out.last_line = (ln == GLYPH_LINES - 1);
         line_expect_q.push_back(line_out);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
      mismatch_count++;
   endtask

   task automatic check_line(input tcgr_rsp_type want, input tcgr_rsp_type got);
      if (got.byte_offset !== want.byte_offset)
         report_mismatch("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
      if (got.pixel_0 !== want.pixel_0) report_mismatch("pixel_0", 32'(want.pixel_0), 32'(got.pixel_0));
      if (got.pixel_1 !== want.pixel_1) report_mismatch("pixel_1", 32'(want.pixel_1), 32'(got.pixel_1));
      if (got.pixel_2 !== want.pixel_2) report_mismatch("pixel_2", 32'(want.pixel_2), 32'(got.pixel_2));
      if (got.pixel_3 !== want.pixel_3) report_mismatch("pixel_3", 32'(want.pixel_3), 32'(got.pixel_3));
      if (got.pixel_4 !== want.pixel_4) report_mismatch("pixel_4", 32'(want.pixel_4), 32'(got.pixel_4));
      if (got.pixel_5 !== want.pixel_5) report_mismatch("pixel_5", 32'(want.pixel_5), 32'(got.pixel_5));
      if (got.pixel_6 !== want.pixel_6) report_mismatch("pixel_6", 32'(want.pixel_6), 32'(got.pixel_6));
      if (got.pixel_7 !== want.pixel_7) report_mismatch("pixel_7", 32'(want.pixel_7), 32'(got.pixel_7));
      if (got.last_line !== want.last_line)
         report_mismatch("last_line", 32'(want.last_line), 32'(got.last_line));
   endtask

   // monitor: request and response transactions seen at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         req_accepted = req_valid && req_ready;
         if (req_accepted)
            predict_glyph_lines(req_data);
         if (rsp_valid && rsp_ready) begin
            if (line_expect_q.size() == 0)
               report_mismatch("unexpected line at offset", 32'd0, 32'(rsp_data.byte_offset));
            else
               check_line(line_expect_q.pop_front(), rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (cell_pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data  <= cell_pending_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side back-pressure, with an occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FRAME_READY: cfg_frame_ready = value[0];
         REG_ORIGIN_X:    cfg_origin_x = value[10:0];
         REG_ORIGIN_Y:    cfg_origin_y = value[10:0];
         REG_LINE_PITCH:  cfg_line_pitch = value[PITCH_W-1:0];
         REG_RGB_ORDER:   cfg_rgb_order = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (cell_pending_q.size() != 0 || req_valid || line_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic tcgr_req_type random_item();
      tcgr_req_type r;
      r.action         = 2'($urandom_range(3));
      r.grid_row       = 5'($urandom);
      r.grid_column    = 7'($urandom);
      r.char_code      = 8'($urandom);
      r.cell_attribute = 8'($urandom);
      r.cursor_visible = 1'($urandom);
      r.font_address   = 12'($urandom);
      r.font_byte      = 8'($urandom);
      return r;
   endfunction

   task automatic queue_item(input logic [1:0] act, input int row, input int col,
                             input logic [7:0] chr, input logic [7:0] attr, input logic vis);
      tcgr_req_type r;
      r = random_item();
      r.action         = act;
      r.grid_row       = 5'(row);
      r.grid_column    = 7'(col);
      r.char_code      = chr;
      r.cell_attribute = attr;
      r.cursor_visible = vis;
      cell_pending_q.push_back(r);
   endtask

   task automatic queue_font(input logic [11:0] addr, input logic [7:0] value);
      tcgr_req_type r;
      logic complete;
      logic [7:0] chr;
      r = random_item();
      r.action       = ACT_FONT;
      r.font_address = addr;
      r.font_byte    = value;
      cell_pending_q.push_back(r);
      font_loaded[addr] = 1'b1;
      chr = addr[11:4];
      complete = 1'b1;
      for (int ln = 0; ln < GLYPH_LINES; ln++)
         complete &= font_loaded[{chr, 4'(ln)}];
      if (complete && !glyph_usable[chr]) begin
         glyph_usable[chr] = 1'b1;
         usable_glyphs.push_back(chr);
      end
   endtask

   task automatic load_glyph(input logic [7:0] chr);
      for (int ln = 0; ln < GLYPH_LINES; ln++)
         queue_font({chr, 4'(ln)}, 8'($urandom));
   endtask

   function automatic logic [7:0] pick_glyph();
      return usable_glyphs[$urandom_range(usable_glyphs.size() - 1)];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_value(input logic [CSR_DATA_W-1:0] typical);
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return typical;
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   task automatic random_settings();
      write_reg(REG_FRAME_READY, {14'($urandom), 1'b1});
      write_reg(REG_ORIGIN_X, pick_value(15'd320));
      write_reg(REG_ORIGIN_Y, pick_value(15'd200));
      write_reg(REG_LINE_PITCH, pick_value(15'(LINE_PITCH_RESET)));
      write_reg(REG_RGB_ORDER, CSR_DATA_W'($urandom));
      if ($urandom_range(1))
         write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), CSR_DATA_W'($urandom));
   endtask

   task automatic queue_random_item();
      int sel;
      int row;
      int col;
      sel = $urandom_range(99);
      row = $urandom_range(GRID_ROWS - 1);
      col = $urandom_range(GRID_COLUMNS - 1);
      if (sel < 50) begin
         queue_item(ACT_PAINT, row, col, pick_glyph(), 8'($urandom), 1'($urandom));
      end else if (sel < 62) begin
         queue_item(ACT_CURSOR, row, col, 8'($urandom), 8'($urandom), $urandom_range(3) != 0);
      end else if (sel < 74) begin
         queue_font(12'($urandom), 8'($urandom));
      end else if (sel < 79) begin
         load_glyph(8'($urandom));
      end else if (sel < 94) begin
         // off the grid in row, column or both
         case ($urandom_range(2))
            0: row = $urandom_range(31, GRID_ROWS);
            1: col = $urandom_range(127, GRID_COLUMNS);
            default: begin
               row = $urandom_range(31, GRID_ROWS);
               col = $urandom_range(127, GRID_COLUMNS);
            end
         endcase
         queue_item($urandom_range(1) ? ACT_CURSOR : ACT_PAINT, row, col, pick_glyph(),
                    8'($urandom), 1'($urandom));
      end else begin
         queue_item(ACT_UNUSED, $urandom_range(31), $urandom_range(127), 8'($urandom),
                    8'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < FONT_DEPTH; i++) begin
         glyph_shadow[i] = '0;
         font_loaded[i] = 1'b0;
      end
      for (int i = 0; i < 256; i++)
         glyph_usable[i] = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // glyph 0 carries the edge patterns, glyph ff reaches the top address
      queue_font(12'h000, 8'h00);
      queue_font(12'h001, 8'hff);
      queue_font(12'h002, 8'h80);
      queue_font(12'h003, 8'h01);
      queue_font(12'h004, 8'haa);
      queue_font(12'h005, 8'h55);
      for (int ln = 6; ln < GLYPH_LINES; ln++)
         queue_font(12'(ln), 8'($urandom));
      load_glyph(8'hff);

      // frame not ready yet: nothing comes back
      queue_item(ACT_PAINT, 3, 3, 8'h00, 8'h1e, 1'b1);
      queue_item(ACT_CURSOR, 3, 3, 8'h00, 8'h1e, 1'b1);
      wait_drained();

      write_reg(REG_FRAME_READY, 15'd1);
      queue_item(ACT_PAINT, 0, 0, 8'h00, 8'h0f, 1'b0);
      queue_item(ACT_PAINT, GRID_ROWS - 1, GRID_COLUMNS - 1, 8'hff, 8'hf0, 1'b1);
      queue_item(ACT_PAINT, 12, 40, pick_glyph(), 8'h7a, 1'b0);
      queue_item(ACT_PAINT, 7, 9, 8'h00, 8'h3c, 1'b1);
      queue_item(ACT_CURSOR, 0, 0, 8'h00, 8'h00, 1'b1);
      queue_item(ACT_CURSOR, GRID_ROWS - 1, GRID_COLUMNS - 1, 8'hff, 8'hff, 1'b1);
      queue_item(ACT_CURSOR, 5, 5, 8'h00, 8'h00, 1'b0);
      queue_item(ACT_PAINT, GRID_ROWS, 0, 8'h00, 8'h12, 1'b1);
      queue_item(ACT_PAINT, 0, GRID_COLUMNS, 8'h00, 8'h12, 1'b1);
      queue_item(ACT_CURSOR, 31, 127, 8'hff, 8'hff, 1'b1);
      queue_item(ACT_UNUSED, 1, 1, 8'h00, 8'h0f, 1'b1);
      wait_drained();

      // widest origin and pitch: offsets wrap, palette swapped
      write_reg(REG_ORIGIN_X, 15'h7fff);
      write_reg(REG_ORIGIN_Y, 15'h07ff);
      write_reg(REG_LINE_PITCH, 15'h7fff);
      write_reg(REG_RGB_ORDER, 15'd0);
      write_reg(REG_UNUSED_LO, 15'h7fff);
      write_reg(REG_UNUSED_HI, 15'h0000);
      queue_item(ACT_PAINT, GRID_ROWS - 1, GRID_COLUMNS - 1, 8'hff, 8'h9c, 1'b0);
      queue_item(ACT_PAINT, 0, 0, 8'h00, 8'h5a, 1'b0);
      queue_item(ACT_CURSOR, GRID_ROWS - 1, GRID_COLUMNS - 1, 8'h00, 8'h00, 1'b1);
      wait_drained();

      // only bit 0 of the ready register counts
      write_reg(REG_FRAME_READY, 15'h7ffe);
      write_reg(REG_LINE_PITCH, 15'd0);
      queue_item(ACT_PAINT, 2, 2, 8'h00, 8'h0f, 1'b1);
      queue_item(ACT_CURSOR, 2, 2, 8'h00, 8'h0f, 1'b1);
      wait_drained();
      write_reg(REG_FRAME_READY, 15'h7fff);
      queue_item(ACT_PAINT, 2, 2, 8'h00, 8'h0f, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         random_settings();
         idle_pct = (phase == 1) ? 0 : IDLE_PCT;
         if (phase == 2) begin
            // receiver holds off while paints keep coming, so the block backs up
            hold_asks = hold_asks + 1;
            for (int i = 0; i < 12; i++)
               queue_item(ACT_PAINT, $urandom_range(GRID_ROWS - 1),
                          $urandom_range(GRID_COLUMNS - 1), pick_glyph(), 8'($urandom), 1'b0);
         end
         for (int i = 0; i < 5; i++)
            queue_random_item();
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
